/* sv/ssdc_pkg.sv */
// Shared types and constants of the divisible-subarray counter.
// Used by ssdc_mod_unit, subarray_sum_divisible_counter, ssdc_checker and tb_top.
`timescale 1ns / 1ps

package ssdc_pkg;

    localparam int VALUE_W = 16;               // input element width
    localparam int DIV_W   = 11;               // divisor register width
    localparam int SUM_W   = VALUE_W + 1;      // remainder plus element, signed
    localparam int MAG_W   = VALUE_W;          // magnitude of that sum
    localparam int STEP_W  = $clog2(MAG_W + 1);
    localparam int COUNT_W = 32;
    localparam int EPOCH_W = 8;                // histogram generation tag

    localparam int DEF_MAX_DIVISOR = 1024;
    localparam int DEF_MAX_LENGTH  = 65536;

    // APB register file
    localparam int ADDR_W = 3;
    localparam int DATA_W = 32;
    localparam logic [ADDR_W-3:0] REG_DIVISOR   = 1'b0;
    localparam logic [DIV_W-1:0]  DIVISOR_RESET = 11'd1;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_START,
        S_DIV,
        S_UPD
    } t_state;

    typedef enum logic [1:0] {
        M_IDLE,
        M_STEP,
        M_FIX
    } t_mod_state;

    typedef struct packed {
        logic             start;
        logic [SUM_W-1:0] sum;   // signed sum, two's complement
        logic [DIV_W-1:0] k;     // effective divisor, never zero
    } t_mod_req;

    typedef struct packed {
        logic             done;
        logic [DIV_W-1:0] rem;   // sum mod k, in 0..k-1
    } t_mod_rsp;

endpackage

/* sv/ssdc_mod_unit.sv */
// Radix-2 restoring remainder unit: signed sum modulo an unsigned divisor.
// Depends on ssdc_pkg for widths and the request/response structs.
`timescale 1ns / 1ps

module ssdc_mod_unit (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  ssdc_pkg::t_mod_req i_req,
    output ssdc_pkg::t_mod_rsp o_rsp
);
    import ssdc_pkg::*;

    t_mod_state        r_state, n_state;
    logic              r_neg;
    logic [MAG_W-1:0]  r_mag;
    logic [DIV_W-1:0]  r_part;
    logic [DIV_W-1:0]  r_k;
    logic [STEP_W-1:0] r_step;
    logic              r_done;

    logic [MAG_W-1:0]  w_abs;
    logic [DIV_W:0]    w_trial;
    logic [DIV_W:0]    w_diff;

    always_comb begin
        w_abs   = i_req.sum[SUM_W-1] ? MAG_W'(-i_req.sum) : i_req.sum[MAG_W-1:0];
        w_trial = {r_part, r_mag[MAG_W-1]};
        w_diff  = w_trial - {1'b0, r_k};
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            M_IDLE: begin
                if (i_req.start) n_state = M_STEP;
            end
            M_STEP: begin
                if (r_step == STEP_W'(MAG_W - 1)) n_state = M_FIX;
            end
            M_FIX:   n_state = M_IDLE;
            default: n_state = M_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= M_IDLE;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_done  <= (r_state == M_FIX);
        end
    end

    // One quotient bit per cycle; the partial remainder always stays below k.
    always_ff @(posedge i_clk) begin
        unique case (r_state)
            M_IDLE: begin
                if (i_req.start) begin
                    r_neg  <= i_req.sum[SUM_W-1];
                    r_mag  <= w_abs;
                    r_part <= '0;
                    r_k    <= i_req.k;
                    r_step <= '0;
                end
            end
            M_STEP: begin
                r_mag  <= r_mag << 1;
                r_part <= (w_trial >= {1'b0, r_k}) ? w_diff[DIV_W-1:0]
                                                   : w_trial[DIV_W-1:0];
                r_step <= r_step + STEP_W'(1);
            end
            M_FIX: begin
                // Negative sums fold back into 0..k-1.
                if (r_neg && (r_part != '0)) r_part <= r_k - r_part;
            end
            default: begin
                r_step <= '0;
            end
        endcase
    end

    assign o_rsp.done = r_done;
    assign o_rsp.rem  = r_part;

endmodule

/* sv/subarray_sum_divisible_counter.sv */
// One request at a time: the next is accepted only after the current one has passed the
// 16-step one-bit-per-cycle remainder unit, the memory read and the update, which waits
// while the previous result is unclaimed. Reset (synchronous, active low) starts a
// clearing pass over the MAX_DIVISOR (at most 2047; 1024 by default) entries of the
// remainder histogram; no request is taken meanwhile. Every 255th new array repeats
// that pass when the histogram tag wraps. Depends on ssdc_pkg and ssdc_mod_unit.
`timescale 1ns / 1ps

module subarray_sum_divisible_counter #(
    parameter int MAX_DIVISOR = ssdc_pkg::DEF_MAX_DIVISOR,
    parameter int MAX_LENGTH  = ssdc_pkg::DEF_MAX_LENGTH
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // Input request stream
    input  logic                          s_axis_tvalid,
    output logic                          s_axis_tready,
    input  logic [ssdc_pkg::VALUE_W-1:0]  s_axis_tdata,   // [15:0] value (signed)
    input  logic                          s_axis_tuser,   // [0] first
    input  logic                          s_axis_tlast,   // last
    // Result stream
    output logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    output logic [ssdc_pkg::COUNT_W-1:0]  m_axis_tdata,   // [31:0] count
    output logic                          m_axis_tuser,   // [0] saturated
    output logic                          m_axis_tlast,   // done_res
    // Configuration
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [ssdc_pkg::ADDR_W-1:0]   paddr,
    input  logic [ssdc_pkg::DATA_W-1:0]   pwdata,
    output logic [ssdc_pkg::DATA_W-1:0]   prdata,
    output logic                          pready
);
    import ssdc_pkg::*;

    // The divisor register can hold at most 2047, so no remainder can exceed that
    // even when MAX_DIVISOR is larger; the histogram holds one entry per remainder.
    localparam int DIV_CAP = (1 << DIV_W) - 1;
    localparam int K_CAP   = (MAX_DIVISOR > DIV_CAP) ? DIV_CAP : MAX_DIVISOR;
    localparam int REM_W   = $clog2(K_CAP);
    localparam int HIST_W  = $clog2(MAX_LENGTH) + 1;
    localparam int WORD_W  = EPOCH_W + HIST_W;

    localparam logic [DIV_W-1:0]   K_CAP_V     = DIV_W'(K_CAP);
    localparam logic [REM_W-1:0]   LAST_IDX    = REM_W'(K_CAP - 1);
    localparam logic [HIST_W-1:0]  HIST_MAX    = {HIST_W{1'b1}};
    localparam logic [EPOCH_W-1:0] EPOCH_FIRST = EPOCH_W'(1);
    localparam logic [EPOCH_W-1:0] EPOCH_LAST  = {EPOCH_W{1'b1}};

    // ------------------------------------------------------------------
    // Configuration register. Each request takes the divisor as it stands
    // at the moment the request is accepted.
    // ------------------------------------------------------------------
    logic [DIV_W-1:0] r_divisor;
    logic             w_reg_hit;

    assign w_reg_hit = (paddr[ADDR_W-1:2] == REG_DIVISOR);
    assign pready    = 1'b1;
    assign prdata    = w_reg_hit ? DATA_W'(r_divisor) : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_divisor <= DIVISOR_RESET;
        end else if (psel && penable && pwrite && pready && w_reg_hit) begin
            r_divisor <= pwdata[DIV_W-1:0];
        end
    end

    // Zero is taken as one, and anything above the histogram size is clamped.
    logic [DIV_W-1:0] w_k;
    assign w_k = (r_divisor == '0)     ? DIV_W'(1) :
                 (r_divisor > K_CAP_V) ? K_CAP_V   : r_divisor;

    // ------------------------------------------------------------------
    // State
    // ------------------------------------------------------------------
    t_state             r_state, n_state;
    logic [EPOCH_W-1:0] r_epoch, n_epoch;
    logic [REM_W-1:0]   r_clr_idx, n_clr_idx;
    logic               r_pend, n_pend;       // a request waits for the clearing pass
    logic [COUNT_W-1:0] r_count, n_count;
    logic               r_sat, n_sat;
    logic               r_out_valid, n_out_valid;
    logic [REM_W-1:0]   r_rem;                // running prefix remainder

    logic [SUM_W-1:0]   r_sum;
    logic [DIV_W-1:0]   r_k;
    logic               r_last;
    logic [COUNT_W-1:0] r_out_count;
    logic               r_out_sat;
    logic               r_out_last;

    // Histogram memory. Each word carries a generation tag; a word whose tag
    // differs from the current one belongs to an earlier array and reads as
    // the empty-histogram value (one for remainder zero, zero elsewhere).
    logic [WORD_W-1:0]  r_hist [K_CAP];
    logic [WORD_W-1:0]  r_rd_word;

    logic               w_wr_en;
    logic [REM_W-1:0]   w_wr_addr;
    logic [WORD_W-1:0]  w_wr_data;
    logic               w_rd_en;
    logic [REM_W-1:0]   w_rd_addr;
    logic               w_accept;
    logic               w_upd_go;

    t_mod_req           w_req;
    t_mod_rsp           w_rsp;

    ssdc_mod_unit u_mod (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_req),
        .o_rsp   (w_rsp)
    );

    assign w_req.start = (r_state == S_START);
    assign w_req.sum   = r_sum;
    assign w_req.k     = r_k;
    assign w_rd_addr   = w_rsp.rem[REM_W-1:0];

    always_ff @(posedge i_clk) begin
        if (w_wr_en) r_hist[w_wr_addr] <= w_wr_data;
        if (w_rd_en) r_rd_word <= r_hist[w_rd_addr];
    end

    // ------------------------------------------------------------------
    // Count update from the entry just read
    // ------------------------------------------------------------------
    logic               w_tag_hit;
    logic [HIST_W-1:0]  w_seen;
    logic [HIST_W-1:0]  w_hist_next;
    logic [COUNT_W:0]   w_sum_wide;
    logic [COUNT_W-1:0] w_count_next;
    logic               w_sat_next;

    always_comb begin
        w_tag_hit   = (r_rd_word[WORD_W-1 -: EPOCH_W] == r_epoch);
        w_seen      = w_tag_hit ? r_rd_word[HIST_W-1:0] :
                      ((r_rem == '0) ? HIST_W'(1) : '0);
        w_hist_next = (w_seen == HIST_MAX) ? w_seen : w_seen + HIST_W'(1);
        w_sum_wide  = {1'b0, r_count} + (COUNT_W + 1)'(w_seen);
        if (r_sat) begin
            w_count_next = r_count;
            w_sat_next   = 1'b1;
        end else if (w_sum_wide[COUNT_W]) begin
            w_count_next = '1;
            w_sat_next   = 1'b1;
        end else begin
            w_count_next = w_sum_wide[COUNT_W-1:0];
            w_sat_next   = &w_sum_wide[COUNT_W-1:0];
        end
    end

    // ------------------------------------------------------------------
    // Sequencer
    // ------------------------------------------------------------------
    always_comb begin
        n_state     = r_state;
        n_epoch     = r_epoch;
        n_clr_idx   = r_clr_idx;
        n_pend      = r_pend;
        n_count     = r_count;
        n_sat       = r_sat;
        n_out_valid = r_out_valid && !m_axis_tready;
        w_wr_en     = 1'b0;
        w_wr_addr   = r_clr_idx;
        w_wr_data   = '0;
        w_rd_en     = 1'b0;
        w_accept    = 1'b0;
        w_upd_go    = 1'b0;

        unique case (r_state)
            S_CLEAR: begin
                // Tag zero never matches a live generation.
                w_wr_en = 1'b1;
                if (r_clr_idx == LAST_IDX) begin
                    n_clr_idx = '0;
                    n_epoch   = EPOCH_FIRST;
                    n_pend    = 1'b0;
                    n_state   = r_pend ? S_START : S_IDLE;
                end else begin
                    n_clr_idx = r_clr_idx + REM_W'(1);
                end
            end
            S_IDLE: begin
                if (s_axis_tvalid) begin
                    w_accept = 1'b1;
                    n_state  = S_START;
                    if (s_axis_tuser) begin
                        // New array: a fresh tag empties the histogram at once,
                        // unless the tag space is used up and a sweep is needed.
                        n_count = '0;
                        n_sat   = 1'b0;
                        if (r_epoch == EPOCH_LAST) begin
                            n_state = S_CLEAR;
                            n_pend  = 1'b1;
                        end else begin
                            n_epoch = r_epoch + EPOCH_W'(1);
                        end
                    end
                end
            end
            S_START: begin
                n_state = S_DIV;
            end
            S_DIV: begin
                if (w_rsp.done) begin
                    w_rd_en = 1'b1;
                    n_state = S_UPD;
                end
            end
            S_UPD: begin
                // Wait here only while the previous result is still unclaimed.
                if (!r_out_valid || m_axis_tready) begin
                    w_upd_go    = 1'b1;
                    w_wr_en     = 1'b1;
                    w_wr_addr   = r_rem;
                    w_wr_data   = {r_epoch, w_hist_next};
                    n_count     = w_count_next;
                    n_sat       = w_sat_next;
                    n_out_valid = 1'b1;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_CLEAR;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_epoch     <= EPOCH_FIRST;
            r_clr_idx   <= '0;
            r_pend      <= 1'b0;
            r_count     <= '0;
            r_sat       <= 1'b0;
            r_out_valid <= 1'b0;
            r_rem       <= '0;
        end else begin
            r_state     <= n_state;
            r_epoch     <= n_epoch;
            r_clr_idx   <= n_clr_idx;
            r_pend      <= n_pend;
            r_count     <= n_count;
            r_sat       <= n_sat;
            r_out_valid <= n_out_valid;
            if (r_state == S_DIV && w_rsp.done) r_rem <= w_rd_addr;
        end
    end

    // A new array starts from remainder zero before the element is added.
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_sum  <= {s_axis_tdata[VALUE_W-1], s_axis_tdata}
                      + (s_axis_tuser ? '0 : SUM_W'(r_rem));
            r_k    <= w_k;
            r_last <= s_axis_tlast;
        end
        if (w_upd_go) begin
            r_out_count <= w_count_next;
            r_out_sat   <= w_sat_next;
            r_out_last  <= r_last;
        end
    end

    assign s_axis_tready = (r_state == S_IDLE);
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_count;
    assign m_axis_tuser  = r_out_sat;
    assign m_axis_tlast  = r_out_last;

endmodule

/* sv/ssdc_checker.sv */
// Port-level assertions for subarray_sum_divisible_counter, bound to the top.
// Depends on ssdc_pkg for port widths.
`timescale 1ns / 1ps

module ssdc_checker (
    input logic                         i_clk,
    input logic                         i_rst_n,
    input logic                         s_axis_tvalid,
    input logic                         s_axis_tready,
    input logic                         m_axis_tvalid,
    input logic                         m_axis_tready,
    input logic [ssdc_pkg::COUNT_W-1:0] m_axis_tdata,
    input logic                         m_axis_tuser
);
    import ssdc_pkg::*;

    // The histogram sweep after reset keeps the input side closed; checked as reset is released.
    a_closed_after_reset: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !$past(i_rst_n) |-> !s_axis_tready)
        else $error("input ready right after reset");

    // One request is worked on at a time.
    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
        else $error("request accepted while another is in work");

    // The saturated flag is only shown with the count stuck at its maximum.
    a_sat_means_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tuser) |-> (m_axis_tdata == {COUNT_W{1'b1}}))
        else $error("saturated flag without maximum count");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(m_axis_tdata)))
        else $error("stalled result changed");

endmodule

bind subarray_sum_divisible_counter ssdc_checker u_ssdc_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
);

/* test/tb_top.sv */
// Self-checking testbench for subarray_sum_divisible_counter: streams signed elements,
// predicts every running count in place, and checks each result in order.
// Depends on ssdc_pkg and the RTL of the counter.
`timescale 1ns / 1ps

module tb_top;

    import ssdc_pkg::*;

    localparam logic [ADDR_W-1:0] DIVISOR_ADDR  = {REG_DIVISOR, 2'b00};
    localparam int                RANDOM_ITEMS  = 1400;
    localparam int                SETTLE_CYCLES = 24;   // wait for the block to settle back to idle
    localparam logic [COUNT_W-1:0] COUNT_LIMIT  = '1;
    localparam logic [16:0]       TALLY_LIMIT   = '1;

    // One result as the block reports it.
    typedef struct {
        logic [COUNT_W-1:0] count;
        logic               saturated;
        logic               done;
    } t_count_result;

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 s_axis_tvalid;
    logic                 s_axis_tready;
    logic [VALUE_W-1:0]   s_axis_tdata;    // [15:0] value (signed)
    logic                 s_axis_tuser;    // [0] first
    logic                 s_axis_tlast;    // last
    logic                 m_axis_tvalid;
    logic                 m_axis_tready = 1'b0;
    logic [COUNT_W-1:0]   m_axis_tdata;    // [31:0] count
    logic                 m_axis_tuser;    // [0] saturated
    logic                 m_axis_tlast;    // done_res
    logic                 psel;
    logic                 penable;
    logic                 pwrite;
    logic [ADDR_W-1:0]    paddr;
    logic [DATA_W-1:0]    pwdata;
    logic [DATA_W-1:0]    prdata;
    logic                 pready;

    subarray_sum_divisible_counter uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    // Predicted state of the counter. It mirrors what the block must hold: the
    // divisor register, the prefix remainder, the remainder histogram, the
    // running count and its saturation flag.
    logic [DIV_W-1:0]   divisor_reg;
    logic [9:0]         prefix_rem;
    logic [16:0]        remainder_tally [DEF_MAX_DIVISOR];
    logic [COUNT_W-1:0] running_total;
    logic               total_stuck;

    t_count_result pending_counts[$];
    int            mismatch_count;

    // Traffic shaping. The sender works in bursts, the receiver stalls on its
    // own random schedule, and each side can be switched to run flat out.
    bit tx_gap_on;
    bit rx_stall_on;
    int burst_left;
    int rx_stall_left;

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    // Fixed ceiling on the run. The slowest correct run is far below it: about
    // 1500 requests, each with its processing time, a possible sender gap and a
    // possible receiver stall, plus the histogram clearing passes.
    initial begin
        #20_000_000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    // The divisor the block actually uses: zero acts as one, and anything above
    // the histogram size is clipped to it.
    function automatic int active_divisor();
        if (divisor_reg == '0)
            return 1;
        if (int'(divisor_reg) > DEF_MAX_DIVISOR)
            return DEF_MAX_DIVISOR;
        return int'(divisor_reg);
    endfunction

    // A new array forgets everything except the divisor. The empty prefix
    // counts as one occurrence of remainder zero.
    function automatic void open_array();
        foreach (remainder_tally[i])
            remainder_tally[i] = '0;
        remainder_tally[0] = 17'd1;
        prefix_rem    = '0;
        running_total = '0;
        total_stuck   = 1'b0;
    endfunction

    // Takes one accepted element into the predicted state and queues the
    // count the block must report for it.
    function automatic void tally_element(logic signed [VALUE_W-1:0] value,
                                          logic is_first, logic is_last);
        int                 k;
        int                 sum;
        int                 rem;
        logic [16:0]        seen;
        longint unsigned    grown;
        t_count_result      want;

        k = active_divisor();
        if (is_first)
            open_array();

        // SystemVerilog % truncates toward zero, so a negative sum needs one
        // more k to land in 0..k-1.
        sum = int'(prefix_rem) + int'(value);
        rem = sum % k;
        if (rem < 0)
            rem += k;
        prefix_rem = rem[9:0];

        // Every earlier prefix with the same remainder closes one divisible
        // subarray ending here.
        seen = remainder_tally[rem];
        if (!total_stuck) begin
            grown = longint'(running_total) + longint'(seen);
            if (grown >= longint'(COUNT_LIMIT)) begin
                running_total = COUNT_LIMIT;
                total_stuck   = 1'b1;
            end else begin
                running_total = grown[COUNT_W-1:0];
            end
        end
        if (seen != TALLY_LIMIT)
            remainder_tally[rem] = seen + 17'd1;

        want.count     = running_total;
        want.saturated = total_stuck;
        want.done      = is_last;
        pending_counts.push_back(want);
    endfunction

    // Sends one request. It is entered and left at a falling edge. tvalid is
    // left high afterwards so that the next request can follow back to back;
    // pause_sender() takes it down.
    task automatic send_element(logic signed [VALUE_W-1:0] value,
                                logic is_first, logic is_last);
        int gap;

        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 12);
            gap = (tx_gap_on && $urandom_range(0, 3) != 0) ? $urandom_range(1, 30) : 0;
            if (gap > 0) begin
                s_axis_tvalid <= 1'b0;
                repeat (gap) @(negedge i_clk);
            end
        end
        burst_left--;

        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= value;
        s_axis_tuser  <= is_first;
        s_axis_tlast  <= is_last;
        do
            @(posedge i_clk);
        while (!s_axis_tready);
        tally_element(value, is_first, is_last);
        @(negedge i_clk);
    endtask

    task automatic pause_sender();
        s_axis_tvalid <= 1'b0;
        @(negedge i_clk);
    endtask

    // Stops sending and waits until every queued count has been reported,
    // then lets the block settle back to idle.
    task automatic drain();
        pause_sender();
        while (pending_counts.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    // Writes the divisor register and reads it back. The bits above the
    // register are filled with junk, which the block must drop.
    task automatic write_divisor(logic [DIV_W-1:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= DIVISOR_ADDR;
        pwdata  <= {(DATA_W - DIV_W)'($urandom), value};
        @(negedge i_clk);
        penable <= 1'b1;
        do
            @(posedge i_clk);
        while (!pready);
        divisor_reg = value;
        @(negedge i_clk);

        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(negedge i_clk);
        penable <= 1'b1;
        do
            @(posedge i_clk);
        while (!pready);
        if (prdata[DIV_W-1:0] !== divisor_reg) begin
            $display("%0t: divisor readback expected %0d, got %0d",
                     $time, divisor_reg, prdata[DIV_W-1:0]);
            mismatch_count++;
        end
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        @(negedge i_clk);
    endtask

    // Result checker: each accepted result is held against the oldest
    // prediction, one field at a time.
    always @(posedge i_clk) begin
        t_count_result want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (pending_counts.size() == 0) begin
                $display("%0t: unexpected result, count %0d saturated %0b done %0b",
                         $time, m_axis_tdata, m_axis_tuser, m_axis_tlast);
                mismatch_count++;
            end else begin
                want = pending_counts.pop_front();
                if (m_axis_tdata !== want.count) begin
                    $display("%0t: count expected %0d, got %0d",
                             $time, want.count, m_axis_tdata);
                    mismatch_count++;
                end
                if (m_axis_tuser !== want.saturated) begin
                    $display("%0t: saturated expected %0b, got %0b",
                             $time, want.saturated, m_axis_tuser);
                    mismatch_count++;
                end
                if (m_axis_tlast !== want.done) begin
                    $display("%0t: done expected %0b, got %0b",
                             $time, want.done, m_axis_tlast);
                    mismatch_count++;
                end
            end
        end
    end

    // Receiver: ready except during stalls, which have random length and
    // start at random points and so land on every phase of the block's work.
    always @(negedge i_clk) begin
        if (rx_stall_left > 0) begin
            m_axis_tready <= 1'b0;
            rx_stall_left <= rx_stall_left - 1;
        end else if (rx_stall_on && $urandom_range(0, 5) == 0) begin
            m_axis_tready <= 1'b0;
            rx_stall_left <= $urandom_range(0, 39);
        end else begin
            m_axis_tready <= 1'b1;
        end
    end

    // Picks an element. Besides full-range values it favors small values and
    // multiples of k, since those make divisible sums common.
    function automatic logic signed [VALUE_W-1:0] pick_value(int k);
        int m;
        case ($urandom_range(0, 9))
            0: return 16'sh8000;
            1: return 16'sh7FFF;
            2, 3, 4: return VALUE_W'($urandom);
            5, 6: return VALUE_W'($urandom_range(0, 2 * k) - k);
            7: begin
                m = $urandom_range(0, 32767 / k) * k;
                return VALUE_W'(($urandom_range(0, 1) != 0) ? -m : m);
            end
            8: return '0;
            default: return VALUE_W'($urandom_range(0, 40) - 20);
        endcase
    endfunction

    // Picks a divisor, the extremes and the clipped range included.
    function automatic logic [DIV_W-1:0] pick_divisor();
        case ($urandom_range(0, 9))
            0: return '0;
            1: return DIV_W'(1);
            2: return DIV_W'(2);
            3, 4: return DIV_W'($urandom_range(3, 16));
            5: return DIV_W'($urandom_range(1, DEF_MAX_DIVISOR));
            6: return DIV_W'(DEF_MAX_DIVISOR);
            7: return DIV_W'($urandom_range(DEF_MAX_DIVISOR + 1, 2047));
            8: return '1;
            default: return DIV_W'($urandom);
        endcase
    endfunction

    // Right after reset, without any first flag, the block must already act
    // as if a fresh array had started, with divisor one.
    task automatic test_reset_state();
        send_element(16'sh8000, 1'b0, 1'b0);
        send_element(16'sh7FFF, 1'b0, 1'b0);
        send_element(16'sh0000, 1'b0, 1'b0);
        send_element(-16'sd1,   1'b0, 1'b1);
        drain();
    endtask

    // Divisor zero acts as one; values above the histogram size are clipped.
    task automatic test_divisor_clamps();
        write_divisor('0);
        send_element(16'sd5,  1'b1, 1'b0);
        send_element(-16'sd3, 1'b0, 1'b1);
        drain();
        write_divisor('1);
        send_element(16'sh7FFF, 1'b1, 1'b0);
        send_element(16'sh8000, 1'b0, 1'b0);
        send_element(16'sd1,    1'b0, 1'b1);
        drain();
        write_divisor(DIV_W'(DEF_MAX_DIVISOR));
        send_element(-16'sd1024, 1'b1, 1'b0);
        send_element(16'sd1024,  1'b0, 1'b1);
        drain();
    endtask

    // Mixed signs with a small divisor, so negative sums need the remainder
    // folded back into range.
    task automatic test_mixed_signs();
        write_divisor(DIV_W'(7));
        send_element(16'sd7,    1'b1, 1'b0);
        send_element(-16'sd3,   1'b0, 1'b0);
        send_element(16'sd3,    1'b0, 1'b0);
        send_element(16'sh8000, 1'b0, 1'b0);
        send_element(16'sh7FFF, 1'b0, 1'b1);
        drain();
    endtask

    // Changing the divisor in the middle of an array keeps the histogram and
    // reduces the stored remainder by the new divisor.
    task automatic test_divisor_change_mid_array();
        write_divisor(DIV_W'(5));
        send_element(16'sd4, 1'b1, 1'b0);
        send_element(16'sd6, 1'b0, 1'b0);
        drain();
        write_divisor(DIV_W'(3));
        send_element(16'sd2,  1'b0, 1'b0);
        send_element(-16'sd1, 1'b0, 1'b1);
        drain();
    endtask

    // Random arrays in phases. Each phase runs a few arrays under one divisor
    // and ends with the sender pausing until every count is in, then a new
    // divisor. Now and then an array carries on across a divisor change, and a
    // few first and last flags are flipped to model broken framing.
    task automatic test_random_arrays();
        int  sent;
        int  arrays;
        int  len;
        bit  carry_on;
        logic is_first;
        logic is_last;

        sent = 0;
        while (sent < RANDOM_ITEMS) begin
            tx_gap_on   = ($urandom_range(0, 3) != 0);
            rx_stall_on = ($urandom_range(0, 3) != 0);
            arrays = $urandom_range(1, 6);
            for (int a = 0; a < arrays; a++) begin
                len = ($urandom_range(0, 15) == 0) ? $urandom_range(60, 150)
                                                   : $urandom_range(1, 24);
                carry_on = (a == 0 && sent > 0 && $urandom_range(0, 4) == 0);
                for (int i = 0; i < len; i++) begin
                    is_first = (i == 0 && !carry_on);
                    is_last  = (i == len - 1);
                    if ($urandom_range(0, 40) == 0)
                        is_first = !is_first;
                    if ($urandom_range(0, 40) == 0)
                        is_last = !is_last;
                    send_element(pick_value(active_divisor()), is_first, is_last);
                    sent++;
                end
            end
            drain();
            write_divisor(pick_divisor());
        end
    endtask

    initial begin
        i_rst_n       = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = 1'b0;
        s_axis_tlast  = 1'b0;
        psel          = 1'b0;
        penable       = 1'b0;
        pwrite        = 1'b0;
        paddr         = '0;
        pwdata        = '0;
        tx_gap_on     = 1'b0;
        rx_stall_on   = 1'b0;
        burst_left    = 0;
        rx_stall_left = 0;
        mismatch_count = 0;
        divisor_reg   = DIVISOR_RESET;
        open_array();

        // The block clears its histogram after reset and holds tready low
        // meanwhile; the sender simply waits on the handshake.
        repeat (7) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        test_reset_state();
        tx_gap_on   = 1'b1;
        rx_stall_on = 1'b1;
        test_divisor_clamps();
        test_mixed_signs();
        test_divisor_change_mid_array();
        test_random_arrays();

        drain();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (pending_counts.size() != 0) begin
            $display("%0t: %0d results never arrived", $time, pending_counts.size());
            mismatch_count++;
        end

        if (mismatch_count == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

/* files.f */
sv/ssdc_pkg.sv
sv/ssdc_mod_unit.sv
sv/subarray_sum_divisible_counter.sv
sv/ssdc_checker.sv
test/tb_top.sv
